// File: hdl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int OP_W      = 3;
  localparam int PRIO_W    = 16;
  localparam int TAG_W     = 32;
  localparam int KIND_W    = 3;
  localparam int OCC_W     = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 3'd0,
    OP_SERVE   = 3'd1,
    OP_NEXT    = 3'd2,
    OP_DISPLAY = 3'd3,
    OP_DELETE  = 3'd4,
    OP_COUNT   = 3'd5
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    K_SERVED  = 3'd0,
    K_PEEK    = 3'd1,
    K_EMPTY   = 3'd2,
    K_HEADER  = 3'd3,
    K_ENTRY   = 3'd4,
    K_COUNT   = 3'd5,
    K_REFUSED = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADD_CMP,
    S_ADD_PUT,
    S_REFUSE,
    S_SERVE,
    S_SHIFT,
    S_DEL_SCAN,
    S_NOTICE,
    S_PEEK,
    S_HEADER,
    S_WALK,
    S_COUNT
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CLR,
    IDX_TOP,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    WA_IDX,
    WA_IDX_P1,
    WA_IDX_M1
  } wr_addr_t;

  typedef enum logic {
    WD_REQ,
    WD_RD
  } wr_data_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_RD,
    SRC_REQ,
    SRC_CNT
  } out_src_t;

  typedef struct packed {
    logic     load;
    logic     rd_en;
    idx_op_t  idx_op;
    logic     wr_en;
    wr_addr_t wr_addr;
    wr_data_t wr_data;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     out_load;
    kind_t    out_kind;
    out_src_t out_src;
    logic     out_last;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
    logic            idx_last;
    logic            idx_zero;
    logic            key_gt;
    logic            tag_match;
    logic            out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: hdl/spq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  spq_pkg::sts_t sts,
  output spq_pkg::cmd_t cmd
);
  import spq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.op)
          OP_ADD: begin
            if (sts.full) begin
              state_nxt = S_REFUSE;
            end else if (sts.empty) begin
              state_nxt = S_ADD_PUT;
            end else begin
              state_nxt = S_ADD_CMP;
            end
          end
          OP_SERVE:   state_nxt = sts.empty ? S_IDLE : S_SERVE;
          OP_NEXT:    state_nxt = sts.empty ? S_NOTICE : S_PEEK;
          OP_DISPLAY: state_nxt = sts.empty ? S_NOTICE : S_HEADER;
          OP_DELETE:  state_nxt = sts.empty ? S_IDLE : S_DEL_SCAN;
          OP_COUNT:   state_nxt = sts.empty ? S_COUNT : S_WALK;
          default:    state_nxt = S_IDLE;
        endcase
      end
      S_ADD_CMP: begin
        if (sts.key_gt) begin
          state_nxt = sts.idx_zero ? S_ADD_PUT : S_ADD_CMP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ADD_PUT: state_nxt = S_IDLE;
      S_REFUSE, S_NOTICE, S_PEEK, S_COUNT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SERVE: begin
        if (sts.out_free) begin
          state_nxt = sts.idx_last ? S_IDLE : S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sts.idx_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_DEL_SCAN: begin
        if (sts.idx_last) begin
          state_nxt = S_IDLE;
        end else if (sts.tag_match) begin
          state_nxt = S_SHIFT;
        end
      end
      S_HEADER: begin
        if (sts.out_free) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.out_free && sts.idx_last) begin
          state_nxt = (sts.op == OP_COUNT) ? S_COUNT : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
      end
      S_DECODE: begin
        unique case (sts.op)
          OP_ADD: begin
            if (!sts.full && sts.empty) begin
              cmd.idx_op = IDX_CLR;
            end else if (!sts.full) begin
              cmd.idx_op = IDX_TOP;
              cmd.rd_en  = 1'b1;
            end
          end
          OP_SERVE, OP_NEXT, OP_DELETE, OP_COUNT: begin
            if (!sts.empty) begin
              cmd.idx_op = IDX_CLR;
              cmd.rd_en  = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_ADD_CMP: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = WA_IDX_P1;
        if (sts.key_gt) begin
          cmd.wr_data = WD_RD;
          if (!sts.idx_zero) begin
            cmd.idx_op = IDX_DEC;
            cmd.rd_en  = 1'b1;
          end
        end else begin
          cmd.wr_data = WD_REQ;
          cmd.cnt_inc = 1'b1;
        end
      end
      S_ADD_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = WA_IDX;
        cmd.wr_data = WD_REQ;
        cmd.cnt_inc = 1'b1;
      end
      S_REFUSE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = K_REFUSED;
          cmd.out_src  = SRC_REQ;
          cmd.out_last = 1'b1;
        end
      end
      S_SERVE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = K_SERVED;
          cmd.out_src  = SRC_RD;
          cmd.out_last = 1'b1;
          if (sts.idx_last) begin
            cmd.cnt_dec = 1'b1;
          end else begin
            cmd.idx_op = IDX_INC;
            cmd.rd_en  = 1'b1;
          end
        end
      end
      S_SHIFT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = WA_IDX_M1;
        cmd.wr_data = WD_RD;
        if (sts.idx_last) begin
          cmd.cnt_dec = 1'b1;
        end else begin
          cmd.idx_op = IDX_INC;
          cmd.rd_en  = 1'b1;
        end
      end
      S_DEL_SCAN: begin
        if (sts.tag_match && sts.idx_last) begin
          cmd.cnt_dec = 1'b1;
        end else if (!sts.idx_last) begin
          cmd.idx_op = IDX_INC;
          cmd.rd_en  = 1'b1;
        end
      end
      S_NOTICE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = K_EMPTY;
          cmd.out_src  = SRC_ZERO;
          cmd.out_last = 1'b1;
        end
      end
      S_PEEK: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = K_PEEK;
          cmd.out_src  = SRC_RD;
          cmd.out_last = 1'b1;
        end
      end
      S_HEADER: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = K_HEADER;
          cmd.out_src  = SRC_ZERO;
          cmd.idx_op   = IDX_CLR;
          cmd.rd_en    = 1'b1;
        end
      end
      S_WALK: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = K_ENTRY;
          cmd.out_src  = SRC_RD;
          cmd.out_last = (sts.op == OP_DISPLAY) && sts.idx_last;
          if (!sts.idx_last) begin
            cmd.idx_op = IDX_INC;
            cmd.rd_en  = 1'b1;
          end
        end
      end
      S_COUNT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = K_COUNT;
          cmd.out_src  = SRC_CNT;
          cmd.out_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/spq_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_dpath #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  spq_pkg::cmd_t                     cmd,
  output spq_pkg::sts_t                     sts,
  input  logic [spq_pkg::OP_W-1:0]          in_op,
  input  logic signed [spq_pkg::PRIO_W-1:0] in_priority_req,
  input  logic [spq_pkg::TAG_W-1:0]         in_tag,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [spq_pkg::KIND_W-1:0]        out_kind,
  output logic signed [spq_pkg::PRIO_W-1:0] out_priority,
  output logic [spq_pkg::TAG_W-1:0]         out_tag,
  output logic [spq_pkg::OCC_W-1:0]         out_occupancy,
  output logic                              out_last
);
  import spq_pkg::*;

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int EW  = PRIO_W + TAG_W;
  localparam int OXW = CW + OCC_W;

  logic [EW-1:0]           mem [DEPTH];
  logic [EW-1:0]           rd_q_r;
  logic [EW-1:0]           wd;
  logic [AW-1:0]           wa;
  logic signed [PRIO_W-1:0] rd_prio;
  logic [TAG_W-1:0]        rd_tag;

  logic [OP_W-1:0]          op_r;
  logic signed [PRIO_W-1:0] prio_r;
  logic [TAG_W-1:0]         tag_r;

  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] idx_r;
  logic [AW-1:0] idx_nxt;
  logic [OXW-1:0] occ_ext;

  logic                     out_valid_r;
  logic [KIND_W-1:0]        out_kind_r;
  logic signed [PRIO_W-1:0] out_prio_r;
  logic [TAG_W-1:0]         out_tag_r;
  logic [OCC_W-1:0]         out_occ_r;
  logic                     out_last_r;
  logic                     out_free;

  assign rd_prio  = rd_q_r[EW-1 -: PRIO_W];
  assign rd_tag   = rd_q_r[TAG_W-1:0];
  assign cnt_m1   = cnt_r - CW'(1);
  assign out_free = !out_valid_r || !out_stall;
  assign occ_ext  = OXW'(cnt_r);

  always_comb begin
    unique case (cmd.idx_op)
      IDX_HOLD: idx_nxt = idx_r;
      IDX_CLR:  idx_nxt = '0;
      IDX_TOP:  idx_nxt = cnt_m1[AW-1:0];
      IDX_INC:  idx_nxt = idx_r + AW'(1);
      IDX_DEC:  idx_nxt = idx_r - AW'(1);
      default:  idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    unique case (cmd.wr_addr)
      WA_IDX:    wa = idx_r;
      WA_IDX_P1: wa = idx_r + AW'(1);
      WA_IDX_M1: wa = idx_r - AW'(1);
      default:   wa = idx_r;
    endcase
    wd = (cmd.wr_data == WD_RD) ? rd_q_r : {prio_r, tag_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wa] <= wd;
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem[idx_nxt];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      op_r   <= in_op;
      prio_r <= in_priority_req;
      tag_r  <= in_tag;
    end
  end

  assign sts.op        = op_r;
  assign sts.empty     = (cnt_r == '0);
  assign sts.full      = (cnt_r == CW'(DEPTH));
  assign sts.idx_last  = (CW'(idx_r) == cnt_m1);
  assign sts.idx_zero  = (idx_r == '0);
  assign sts.key_gt    = (rd_prio > prio_r);
  assign sts.tag_match = (rd_tag == tag_r);
  assign sts.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind_r <= cmd.out_kind;
      out_last_r <= cmd.out_last;
      unique case (cmd.out_src)
        SRC_ZERO: begin
          out_prio_r <= '0;
          out_tag_r  <= '0;
          out_occ_r  <= '0;
        end
        SRC_RD: begin
          out_prio_r <= rd_prio;
          out_tag_r  <= rd_tag;
          out_occ_r  <= '0;
        end
        SRC_REQ: begin
          out_prio_r <= prio_r;
          out_tag_r  <= tag_r;
          out_occ_r  <= '0;
        end
        SRC_CNT: begin
          out_prio_r <= '0;
          out_tag_r  <= '0;
          out_occ_r  <= occ_ext[OCC_W-1:0];
        end
        default: begin
          out_prio_r <= '0;
          out_tag_r  <= '0;
          out_occ_r  <= '0;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_priority  = out_prio_r;
  assign out_tag       = out_tag_r;
  assign out_occupancy = out_occ_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

// File: hdl/stable_priority_queue.sv
// Stable priority queue: up to DEPTH (priority, tag) entries kept sorted by
// signed priority, lowest first; equal priorities stay in arrival order.
// Input channel (in_valid/in_stall): one request carries op, priority_req and
// tag. Ops: add, serve, next, display, delete, count. Result channel
// (out_valid/out_stall): kind, out_priority, out_tag, out_occupancy, out_last;
// out_last marks the final result of a request. Add and delete give no result
// unless an add is refused on a full store.
// One request is worked at a time. Entries live in a single-port-read,
// single-port-write RAM with registered read data, so entries are moved or
// reported one at a time: add shifts larger entries up from the tail, serve
// reports the head and closes up, delete scans for the tag and closes up,
// display and count walk the store, next reads the head. in_stall is high
// while a request is in progress.
// Results sit in an output register, so a new request is taken while the last
// result still waits; a stalled receiver holds the result and pauses any walk.
// Reset (rst_n low, synchronous) empties the store; the RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [spq_pkg::OP_W-1:0]          in_op,
  input  logic signed [spq_pkg::PRIO_W-1:0] in_priority_req,
  input  logic [spq_pkg::TAG_W-1:0]         in_tag,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [spq_pkg::KIND_W-1:0]        out_kind,
  output logic signed [spq_pkg::PRIO_W-1:0] out_priority,
  output logic [spq_pkg::TAG_W-1:0]         out_tag,
  output logic [spq_pkg::OCC_W-1:0]         out_occupancy,
  output logic                              out_last
);
  import spq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  spq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_op),
    .in_priority_req (in_priority_req),
    .in_tag          (in_tag),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_priority    (out_priority),
    .out_tag         (out_tag),
    .out_occupancy   (out_occupancy),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

// File: bench/stable_priority_queue_tb.sv
`timescale 1ns / 1ps

module stable_priority_queue_tb;
  import spq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 2 * DEPTH + 10;
  localparam int RANDOM_ITEMS = 175;
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]         tag;
    bit                       wait_empty;
  } request_t;

  typedef struct {
    kind_t                    kind;
    logic signed [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]         tag;
    logic [OCC_W-1:0]         occ;
    logic                     last;
  } result_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          in_op = '0;
  logic signed [PRIO_W-1:0] in_priority_req = '0;
  logic [TAG_W-1:0]         in_tag = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [KIND_W-1:0]        out_kind;
  logic signed [PRIO_W-1:0] out_priority;
  logic [TAG_W-1:0]         out_tag;
  logic [OCC_W-1:0]         out_occupancy;
  logic                     out_last;

  stable_priority_queue #(.DEPTH(DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_priority_req(in_priority_req),
    .in_tag         (in_tag),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_priority   (out_priority),
    .out_tag        (out_tag),
    .out_occupancy  (out_occupancy),
    .out_last       (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the sorted store
  logic signed [PRIO_W-1:0] held_prio [DEPTH];
  logic [TAG_W-1:0]         held_tag [DEPTH];
  int                       held_count = 0;

  request_t         pending_reqs[$];
  result_t          expected_results[$];
  logic [TAG_W-1:0] tag_pool[$];

  request_t cur_req;
  int       burst_left = 1;
  int       gap_left = 0;
  int       stall_mode = 0;
  int       stall_phase = 0;
  int       stall_pat = 0;
  int       cycles = 0;
  int       errors = 0;
  int       results_checked = 0;
  int       refused_adds = 0;
  int       drain_pauses = 0;
  int       peak_count = 0;
  int       random_items = 0;
  int       op_seen[8];

  function automatic void push_result(kind_t kind, logic signed [PRIO_W-1:0] prio,
                                      logic [TAG_W-1:0] tag, int occ, logic last);
    result_t r;
    r.kind = kind;
    r.prio = prio;
    r.tag  = tag;
    r.occ  = OCC_W'(occ);
    r.last = last;
    expected_results.push_back(r);
  endfunction

  function automatic void remove_entry(int pos);
    for (int i = pos; i + 1 < held_count; i++) begin
      held_prio[i] = held_prio[i + 1];
      held_tag[i]  = held_tag[i + 1];
    end
    held_count--;
  endfunction

  function automatic void apply_request(request_t r);
    int pos;
    int found;
    op_seen[r.op]++;
    case (r.op)
      OP_ADD: begin
        if (held_count >= DEPTH) begin
          push_result(K_REFUSED, r.prio, r.tag, 0, 1'b1);
          refused_adds++;
        end else begin
          pos = held_count;
          while (pos > 0 && held_prio[pos - 1] > r.prio) begin
            held_prio[pos] = held_prio[pos - 1];
            held_tag[pos]  = held_tag[pos - 1];
            pos--;
          end
          held_prio[pos] = r.prio;
          held_tag[pos]  = r.tag;
          held_count++;
          if (held_count > peak_count) peak_count = held_count;
        end
      end
      OP_SERVE: begin
        if (held_count > 0) begin
          push_result(K_SERVED, held_prio[0], held_tag[0], 0, 1'b1);
          remove_entry(0);
        end
      end
      OP_NEXT: begin
        if (held_count == 0) push_result(K_EMPTY, '0, '0, 0, 1'b1);
        else push_result(K_PEEK, held_prio[0], held_tag[0], 0, 1'b1);
      end
      OP_DISPLAY: begin
        if (held_count == 0) begin
          push_result(K_EMPTY, '0, '0, 0, 1'b1);
        end else begin
          push_result(K_HEADER, '0, '0, 0, 1'b0);
          for (int i = 0; i < held_count; i++)
            push_result(K_ENTRY, held_prio[i], held_tag[i], 0, i == held_count - 1);
        end
      end
      OP_DELETE: begin
        found = -1;
        for (int i = 0; i < held_count && found < 0; i++)
          if (held_tag[i] == r.tag) found = i;
        if (found >= 0) remove_entry(found);
      end
      OP_COUNT: begin
        for (int i = 0; i < held_count; i++)
          push_result(K_ENTRY, held_prio[i], held_tag[i], 0, 1'b0);
        push_result(K_COUNT, '0, '0, held_count, 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic push_req(logic [OP_W-1:0] op, logic signed [PRIO_W-1:0] prio,
                          logic [TAG_W-1:0] tag, bit wait_empty);
    request_t r;
    r.op = op;
    r.prio = prio;
    r.tag = tag;
    r.wait_empty = wait_empty;
    pending_reqs.push_back(r);
  endtask

  function automatic logic signed [PRIO_W-1:0] rand_prio();
    int unsigned sel;
    int v;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      v = int'($urandom_range(0, 4)) - 2;
      return PRIO_W'(v);
    end
    if (sel < 6) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return PRIO_W'($urandom);
  endfunction

  function automatic logic [TAG_W-1:0] rand_tag(bool_from_pool);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (bool_from_pool && tag_pool.size() > 0 && sel < 7)
      return tag_pool[$urandom_range(0, tag_pool.size() - 1)];
    if (sel < 3) return TAG_W'($urandom_range(0, 7));
    return $urandom;
  endfunction

  task automatic random_req(logic [OP_W-1:0] op);
    logic [TAG_W-1:0] t;
    t = rand_tag(op == OP_DELETE);
    if (op == OP_ADD) begin
      tag_pool.push_back(t);
      if (tag_pool.size() > 32) void'(tag_pool.pop_front());
    end
    push_req(op, rand_prio(), t, $urandom_range(0, 24) == 0);
    if (op != OP_RSVD6 && op != OP_RSVD7) random_items++;
  endtask

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return OP_ADD;
    if (sel < 50) return OP_SERVE;
    if (sel < 60) return OP_NEXT;
    if (sel < 70) return OP_DISPLAY;
    if (sel < 85) return OP_DELETE;
    if (sel < 95) return OP_COUNT;
    return $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
  endfunction

  // sender: bursts with random gaps, optional hold until all results drained
  always @(posedge clk) begin
    if (rst_n && !(in_valid && in_stall)) begin
      if (in_valid) apply_request(cur_req);
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0 &&
                   (!pending_reqs[0].wait_empty || expected_results.size() == 0)) begin
        cur_req = pending_reqs.pop_front();
        if (cur_req.wait_empty) drain_pauses++;
        in_valid        <= 1'b1;
        in_op           <= cur_req.op;
        in_priority_req <= cur_req.prio;
        in_tag          <= cur_req.tag;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: phases of none, light, heavy random, and a 3-of-5 pattern
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_phase = $urandom_range(20, 80);
    end else begin
      stall_phase--;
    end
    stall_pat = (stall_pat + 1) % 5;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 1);
      default: out_stall <= (stall_pat < 3);
    endcase
  end

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind %0d prio %0d tag %h occ %0d last %0b",
                   out_kind, out_priority, out_tag, out_occupancy, out_last);
      end else begin
        e = expected_results.pop_front();
        results_checked++;
        if (out_kind !== e.kind || out_priority !== e.prio || out_tag !== e.tag ||
            out_occupancy !== e.occ || out_last !== e.last) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: exp kind %0d prio %0d tag %h occ %0d last %0b",
                     e.kind, e.prio, e.tag, e.occ, e.last);
            $display("          got kind %0d prio %0d tag %h occ %0d last %0b",
                     out_kind, out_priority, out_tag, out_occupancy, out_last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_results.size());
      $display("FAIL stable_priority_queue");
      $finish;
    end
  end

  initial begin
    int unsigned scen;
    foreach (op_seen[i]) op_seen[i] = 0;
    rst_n = 1'b0;

    // empty-store cases and unused op codes
    push_req(OP_NEXT, 16'sh0000, 32'h0000_0000, 1'b0);
    push_req(OP_DISPLAY, 16'sh0000, 32'h0000_0000, 1'b0);
    push_req(OP_COUNT, 16'sh0000, 32'h0000_0000, 1'b0);
    push_req(OP_SERVE, 16'sh7fff, 32'hffff_ffff, 1'b0);
    push_req(OP_DELETE, 16'sh0000, 32'h1234_5678, 1'b0);
    push_req(OP_RSVD6, 16'sh7fff, 32'hffff_ffff, 1'b0);
    push_req(OP_RSVD7, 16'sh8000, 32'h5a5a_a5a5, 1'b0);
    // extremes and equal priorities
    push_req(OP_ADD, 16'sh7fff, 32'hffff_ffff, 1'b0);
    push_req(OP_ADD, 16'sh8000, 32'h0000_0000, 1'b0);
    push_req(OP_ADD, 16'sh0000, 32'h0000_0001, 1'b0);
    push_req(OP_ADD, 16'sh0000, 32'h0000_0002, 1'b0);
    push_req(OP_ADD, 16'shffff, 32'ha5a5_5a5a, 1'b0);
    push_req(OP_NEXT, 16'sh0000, 32'h0000_0000, 1'b1);
    push_req(OP_DISPLAY, 16'sh0000, 32'h0000_0000, 1'b0);
    push_req(OP_COUNT, 16'sh0000, 32'h0000_0000, 1'b0);
    push_req(OP_DELETE, 16'sh0000, 32'h0000_0002, 1'b0);
    push_req(OP_DELETE, 16'sh0000, 32'h0000_dead, 1'b0);
    push_req(OP_DELETE, 16'sh0000, 32'hffff_ffff, 1'b0);
    push_req(OP_SERVE, 16'sh0000, 32'h0000_0000, 1'b0);
    push_req(OP_SERVE, 16'sh0000, 32'h0000_0000, 1'b0);
    push_req(OP_DISPLAY, 16'sh0000, 32'h0000_0000, 1'b0);
    push_req(OP_COUNT, 16'sh0000, 32'h0000_0000, 1'b1);

    while (random_items < RANDOM_ITEMS) begin
      scen = $urandom_range(0, 9);
      if (scen < 2) begin
        // fill past full, then list
        repeat (DEPTH + 2) random_req(OP_ADD);
        random_req($urandom_range(0, 1) ? OP_DISPLAY : OP_COUNT);
      end else if (scen == 2) begin
        repeat (DEPTH + 2) random_req(OP_SERVE);
        random_req(OP_NEXT);
      end else if (scen < 9) begin
        repeat ($urandom_range(4, 12)) random_req(pick_op());
      end else begin
        repeat ($urandom_range(1, 4)) random_req($urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("requests: add %0d serve %0d next %0d display %0d delete %0d count %0d unused %0d",
             op_seen[OP_ADD], op_seen[OP_SERVE], op_seen[OP_NEXT], op_seen[OP_DISPLAY],
             op_seen[OP_DELETE], op_seen[OP_COUNT], op_seen[6] + op_seen[7]);
    $display("%0d results checked, %0d refused adds, peak occupancy %0d, %0d drain pauses",
             results_checked, refused_adds, peak_count, drain_pauses);
    if (errors == 0) begin
      $display("PASS stable_priority_queue");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL stable_priority_queue");
    end
    $finish;
  end

endmodule
